// ===== design/bicv_pkg.sv =====
// package for the boot image crc verifier: payload structs, register map,
// crc constants and the byte-wide crc update function
// no dependencies
`default_nettype none

package bicv_pkg;

   // image fields
   localparam int unsigned SizeWidth = 22;
   localparam int unsigned PosWidth  = SizeWidth + 1;
   localparam int unsigned CrcWidth  = 32;

   localparam logic [CrcWidth-1:0] CrcPoly  = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] CrcInit  = 32'hFFFF_FFFF;
   localparam logic [CrcWidth-1:0] ImageId  = 32'hDEAD_BEEF;

   // header layout, byte offsets from image start
   localparam logic [PosWidth-1:0] PosKey       = 23'd0;
   localparam logic [PosWidth-1:0] PosSizeFirst = 23'd1;
   localparam logic [PosWidth-1:0] PosSizeLast  = 23'd4;
   localparam logic [PosWidth-1:0] PosCrcFirst  = 23'd5;
   localparam logic [PosWidth-1:0] PosIdFirst   = 23'd7;
   localparam logic [PosWidth-1:0] PosIdLast    = 23'd12;
   localparam logic [PosWidth-1:0] TrailerBytes = 23'd4;

   // register map
   localparam int unsigned AddrWidth = 4;
   localparam logic [AddrWidth-1:0] AddrExpectedSize = 4'h0;
   localparam logic [AddrWidth-1:0] AddrExpectedCrc  = 4'h4;
   localparam logic [AddrWidth-1:0] AddrCrcEnable    = 4'h8;

   localparam logic [SizeWidth-1:0] ExpectedSizeReset = 22'd327680;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       image_start;
   } req_type;

   typedef struct packed {
      logic                image_ok;
      logic                header_ok;
      logic                crc_ok;
      logic [CrcWidth-1:0] computed_crc;
   } rsp_type;

   typedef struct packed {
      logic [SizeWidth-1:0] expected_size;
      logic [CrcWidth-1:0]  expected_crc;
      logic                 crc_enable;
   } cfg_type;

   // reflected crc-32, one byte, eight shift steps
   function automatic logic [CrcWidth-1:0] crc_byte_update(
      input logic [CrcWidth-1:0] crc_cur,
      input logic [7:0]          data_byte
   );
      logic [CrcWidth-1:0] c;
      c = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/bicv_csr.sv =====
// configuration registers of the boot image crc verifier, apb-style access
// depends on bicv_pkg
`default_nettype none

module bicv_csr
   import bicv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            AddrExpectedSize: cfg_in.expected_size = pwdata[SizeWidth-1:0];
            AddrExpectedCrc:  cfg_in.expected_crc  = pwdata;
            AddrCrcEnable:    cfg_in.crc_enable    = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_size <= ExpectedSizeReset;
         cfg_ff.expected_crc  <= '0;
         cfg_ff.crc_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr)
         AddrExpectedSize: prdata = {10'd0, cfg_ff.expected_size};
         AddrExpectedCrc:  prdata = cfg_ff.expected_crc;
         AddrCrcEnable:    prdata = {31'd0, cfg_ff.crc_enable};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/bicv_in_stage.sv =====
// input register of the boot image crc verifier
// depends on bicv_pkg
`default_nettype none

module bicv_in_stage
   import bicv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         req_stall,
   input  wire logic    take,
   output logic         s1_valid,
   output req_type      s1_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    accept;

   // stage frees up when the checker takes its byte
   assign req_stall = s1_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

endmodule

`default_nettype wire

// ===== design/bicv_check.sv =====
// header and crc checking state plus result register of the boot image
// crc verifier; depends on bicv_pkg
`default_nettype none

module bicv_check
   import bicv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    s1_valid,
   input  wire req_type s1_data,
   input  wire cfg_type cfg,
   output logic         take,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    rsp_stall
);

   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                key_zero_ff, key_zero_in;
   logic [31:0]         size_word_ff, size_word_in;
   logic [47:0]         id_win_ff, id_win_in;
   logic                active_ff, active_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff, out_data_in;

   logic                step;
   logic                verdict;
   logic [PosWidth-1:0] last_pos;
   logic [CrcWidth-1:0] crc_base;
   logic [PosWidth-1:0] pos_base;
   logic                key_zero_base;
   logic [31:0]         size_word_base;
   logic [47:0]         id_win_base;
   logic                active_base;
   logic [7:0]          b;
   logic                hdr_ok;
   logic                crc_match;
   logic [CrcWidth-1:0] crc_final;

   assign take     = !out_valid_ff || !rsp_stall;
   assign step     = s1_valid && take;
   assign b        = s1_data.image_byte;
   assign last_pos = {1'b0, cfg.expected_size} + TrailerBytes;

   // start byte restarts everything before it is folded in
   always_comb begin
      if (s1_data.image_start) begin
         crc_base       = CrcInit;
         pos_base       = '0;
         key_zero_base  = 1'b1;
         size_word_base = '0;
         id_win_base    = '0;
         active_base    = 1'b1;
      end else begin
         crc_base       = crc_ff;
         pos_base       = pos_ff;
         key_zero_base  = key_zero_ff;
         size_word_base = size_word_ff;
         id_win_base    = id_win_ff;
         active_base    = active_ff;
      end
   end

   always_comb begin
      key_zero_in  = key_zero_base;
      size_word_in = size_word_base;
      id_win_in    = id_win_base;
      crc_in       = crc_base;

      if (pos_base == PosKey) begin
         key_zero_in = (b == 8'd0);
      end

      if (pos_base >= PosSizeFirst && pos_base <= PosSizeLast) begin
         case (pos_base[2:0])
            3'd1:    size_word_in[7:0]   = size_word_base[7:0]   | b;
            3'd2:    size_word_in[15:8]  = size_word_base[15:8]  | b;
            3'd3:    size_word_in[23:16] = size_word_base[23:16] | b;
            3'd4:    size_word_in[31:24] = size_word_base[31:24] | b;
            default: size_word_in = size_word_base;
         endcase
      end

      if (pos_base >= PosIdFirst && pos_base <= PosIdLast) begin
         case (pos_base[3:0])
            4'd7:    id_win_in[7:0]   = id_win_base[7:0]   | b;
            4'd8:    id_win_in[15:8]  = id_win_base[15:8]  | b;
            4'd9:    id_win_in[23:16] = id_win_base[23:16] | b;
            4'd10:   id_win_in[31:24] = id_win_base[31:24] | b;
            4'd11:   id_win_in[39:32] = id_win_base[39:32] | b;
            4'd12:   id_win_in[47:40] = id_win_base[47:40] | b;
            default: id_win_in = id_win_base;
         endcase
      end

      if (pos_base >= PosCrcFirst && pos_base <= last_pos) begin
         crc_in = crc_byte_update(crc_base, b);
      end
   end

   assign verdict   = active_base && (pos_base >= last_pos);
   assign crc_final = ~crc_in;
   assign hdr_ok    = key_zero_in && (size_word_in == {10'd0, cfg.expected_size})
                      && ((id_win_in[31:0] == ImageId) || (id_win_in[47:16] == ImageId));
   assign crc_match = !cfg.crc_enable || (crc_final == cfg.expected_crc);

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      if (step) begin
         active_in = active_base && !verdict;
         if (!active_base) begin
            pos_in = pos_ff;
         end else if (verdict) begin
            pos_in = '0;
         end else begin
            pos_in = pos_base + 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (take) begin
         out_valid_in = step && verdict;
      end
      if (step && verdict) begin
         out_data_in.image_ok     = hdr_ok && crc_match;
         out_data_in.header_ok    = hdr_ok;
         out_data_in.crc_ok       = crc_match;
         out_data_in.computed_crc = crc_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CrcInit;
         pos_ff       <= '0;
         key_zero_ff  <= 1'b1;
         size_word_ff <= '0;
         id_win_ff    <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step && active_base) begin
            crc_ff       <= crc_in;
            key_zero_ff  <= key_zero_in;
            size_word_ff <= size_word_in;
            id_win_ff    <= id_win_in;
         end
         pos_ff       <= pos_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== design/boot_image_crc_verifier_core.sv =====
// top level of the boot image crc verifier: csr block, input register and
// checker with result register; depends on bicv_pkg and the bicv_* modules
`default_nettype none

//  channel   ports                         direction  transaction
//  req       req_valid req_stall req_data  in         one image byte
//  rsp       rsp_valid rsp_stall rsp_data  out        one verdict per image
//  csr       psel penable pwrite paddr ... in         register write or read
//
//  one byte per cycle sustained while no verdict is stalled: input register,
//  one pass through the unrolled 8-bit crc update and header compare, then
//  the result register; the verdict reaches rsp_valid once the checker
//  takes the last image byte from the input register and registers it
//  synchronous active-high reset clears checking state and loads register
//  defaults; a stalled verdict holds in the result register while one more
//  byte waits in the input register, after which req_stall rises

module boot_image_crc_verifier_core
   import bicv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // byte stream in
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   // verdict out
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   // configuration
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready
);

   cfg_type cfg;
   logic    take;
   logic    s1_valid;
   req_type s1_data;

   // register file, sampled live by the checker
   bicv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register, stalls only when the checker cannot take its byte
   bicv_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .take      (take),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data)
   );

   // header capture, crc fold and verdict register
   bicv_check u_check (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .cfg       (cfg),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire
